@@ rtl/nnis_pkg.sv @@
// ----------------------------------------------------------------------------
// nnis_pkg: shared types and constants for the nearest neighbor scaler
// Beat layouts, request codes, register indexes and FSM states.
// ----------------------------------------------------------------------------
package nnis_pkg;

  // Default geometry and fixed-point format
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed field widths
  localparam int COORD_W   = 10;
  localparam int PIXEL_W   = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  // Size register reset value
  localparam logic [CFG_W-1:0] SIZE_RST = 11'd1024;

  // Request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_TGT_WIDTH  = 2'd2,
    CFG_TGT_HEIGHT = 2'd3
  } cfg_idx_t;

  // Input beat
  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [PIXEL_W-1:0] pixel_in;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic [COORD_W-1:0] picked_x;
    logic [COORD_W-1:0] picked_y;
  } out_item_t;

  // Item sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_PICK,
    ST_READ
  } st_t;

endpackage

@@ rtl/nearest_neighbour_image_scaler.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbour_image_scaler: nearest neighbor greyscale frame scaler
// Stores a source frame; read beats return the nearest source pixel for a
// destination coordinate scaled by fixed-point step ratios.
// ----------------------------------------------------------------------------
//  Channel | Ports                          | Beat
//  --------+--------------------------------+-------------------------------
//  in      | in_valid, in_stall, in_data    | write pixel / read request
//  out     | out_valid, out_stall, out_data | pixel and chosen source place
//  cfg     | cfg_we, cfg_index, cfg_data    | frame size register write
//
//  A read passes the multiply, round and clamp, and memory read steps
//  before its result is registered; a write is stored in the multiply
//  step. One item is in work at a time.
//  After reset and after every size write, in_stall stays high while
//  the step dividers run.
//  A result held by out_stall keeps the next read in its memory-read step;
//  a new item is still accepted while the result waits.
// ----------------------------------------------------------------------------
module nearest_neighbour_image_scaler
  import nnis_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Derived widths
  localparam int CWX   = $clog2(MAX_WIDTH + 1);
  localparam int CWY   = $clog2(MAX_HEIGHT + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = MAX_HEIGHT * (2 ** XW);
  localparam int XS_W  = CWX + FRAC_BITS;
  localparam int YS_W  = CWY + FRAC_BITS;
  localparam int PX_W  = COORD_W + XS_W;
  localparam int PY_W  = COORD_W + YS_W;
  localparam int WX_W  = PX_W + 1 - FRAC_BITS;
  localparam int WY_W  = PY_W + 1 - FRAC_BITS;
  localparam logic [PX_W:0] RND_X = (PX_W + 1)'((1 << (FRAC_BITS - 1)) - 1);
  localparam logic [PY_W:0] RND_Y = (PY_W + 1)'((1 << (FRAC_BITS - 1)) - 1);

  // Size registers
  logic [CFG_W-1:0] src_w_r, src_h_r, tgt_w_r, tgt_h_r;
  logic             recalc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r  <= SIZE_RST;
      src_h_r  <= SIZE_RST;
      tgt_w_r  <= SIZE_RST;
      tgt_h_r  <= SIZE_RST;
      recalc_r <= 1'b1;
    end else begin
      recalc_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SRC_WIDTH:  src_w_r <= cfg_data;
          CFG_SRC_HEIGHT: src_h_r <= cfg_data;
          CFG_TGT_WIDTH:  tgt_w_r <= cfg_data;
          CFG_TGT_HEIGHT: tgt_h_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Sizes limited to 1..MAX
  logic [CWX-1:0] sw_c, tw_c;
  logic [CWY-1:0] sh_c, th_c;

  always_comb begin
    sw_c = (src_w_r == '0) ? CWX'(1) :
           (int'(src_w_r) > MAX_WIDTH) ? CWX'(MAX_WIDTH) : CWX'(src_w_r);
    tw_c = (tgt_w_r == '0) ? CWX'(1) :
           (int'(tgt_w_r) > MAX_WIDTH) ? CWX'(MAX_WIDTH) : CWX'(tgt_w_r);
    sh_c = (src_h_r == '0) ? CWY'(1) :
           (int'(src_h_r) > MAX_HEIGHT) ? CWY'(MAX_HEIGHT) : CWY'(src_h_r);
    th_c = (tgt_h_r == '0) ? CWY'(1) :
           (int'(tgt_h_r) > MAX_HEIGHT) ? CWY'(MAX_HEIGHT) : CWY'(tgt_h_r);
  end

  // Step ratio dividers
  logic            xdiv_busy, ydiv_busy;
  logic [XS_W-1:0] x_step;
  logic [YS_W-1:0] y_step;

  nnis_div #(.NUM_W(XS_W), .DEN_W(CWX)) u_xdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (recalc_r),
    .num   ({sw_c, {FRAC_BITS{1'b0}}}),
    .den   (tw_c),
    .busy  (xdiv_busy),
    .quot  (x_step)
  );

  nnis_div #(.NUM_W(YS_W), .DEN_W(CWY)) u_ydiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (recalc_r),
    .num   ({sh_c, {FRAC_BITS{1'b0}}}),
    .den   (th_c),
    .busy  (ydiv_busy),
    .quot  (y_step)
  );

  // Item sequencer
  st_t      st_r, st_nxt;
  in_item_t item_r;
  logic     in_acc, out_free;
  logic     mem_we, mem_re, out_load;

  assign in_stall = (st_r != ST_IDLE) || recalc_r || xdiv_busy || ydiv_busy;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    mem_re   = 1'b0;
    out_load = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) st_nxt = ST_MUL;
      end
      ST_MUL: begin
        st_nxt = (item_r.req_type == REQ_WRITE) ? ST_IDLE : ST_PICK;
      end
      ST_PICK: begin
        mem_re = 1'b1;
        st_nxt = ST_READ;
      end
      ST_READ: begin
        if (out_free) begin
          out_load = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Accepted beat
  always_ff @(posedge clk) begin
    if (in_acc) item_r <= in_data;
  end

  // Position products
  logic [PX_W-1:0] prod_x_r;
  logic [PY_W-1:0] prod_y_r;

  always_ff @(posedge clk) begin
    if (st_r == ST_MUL) begin
      prod_x_r <= PX_W'(item_r.coord_x) * PX_W'(x_step);
      prod_y_r <= PY_W'(item_r.coord_y) * PY_W'(y_step);
    end
  end

  // Round to nearest, tie down, clamp to last column and row
  logic [PX_W:0]   rnd_x;
  logic [PY_W:0]   rnd_y;
  logic [WX_W-1:0] whole_x, lim_x;
  logic [WY_W-1:0] whole_y, lim_y;
  logic [XW-1:0]   px;
  logic [YW-1:0]   py;

  always_comb begin
    rnd_x   = {1'b0, prod_x_r} + RND_X;
    rnd_y   = {1'b0, prod_y_r} + RND_Y;
    whole_x = rnd_x[PX_W:FRAC_BITS];
    whole_y = rnd_y[PY_W:FRAC_BITS];
    lim_x   = WX_W'(sw_c) - WX_W'(1);
    lim_y   = WY_W'(sh_c) - WY_W'(1);
    px      = (whole_x > lim_x) ? XW'(lim_x) : XW'(whole_x);
    py      = (whole_y > lim_y) ? YW'(lim_y) : YW'(whole_y);
  end

  // Frame store access
  logic               wr_in_range;
  logic [AW-1:0]      mem_addr;
  logic [PIXEL_W-1:0] mem_rdata;
  logic [XW-1:0]      px_r;
  logic [YW-1:0]      py_r;

  assign wr_in_range = (int'(item_r.coord_x) < MAX_WIDTH) &&
                       (int'(item_r.coord_y) < MAX_HEIGHT);
  assign mem_we   = (st_r == ST_MUL) && (item_r.req_type == REQ_WRITE) && wr_in_range;
  assign mem_addr = mem_we ? {YW'(item_r.coord_y), XW'(item_r.coord_x)} : {py, px};

  nnis_mem #(.AW(AW), .DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (item_r.pixel_in),
    .rdata (mem_rdata)
  );

  // Chosen place, kept for the result beat
  always_ff @(posedge clk) begin
    if (mem_re) begin
      px_r <= px;
      py_r <= py;
    end
  end

  // Output register
  logic      out_valid_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.pixel_out <= mem_rdata;
      out_data_r.picked_x  <= COORD_W'(px_r);
      out_data_r.picked_y  <= COORD_W'(py_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/nnis_div.sv @@
// ----------------------------------------------------------------------------
// nnis_div: restoring divider for the step ratio
// One quotient bit per cycle, MSB first. A start pulse restarts it.
// ----------------------------------------------------------------------------
module nnis_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] work_r, work_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W:0]   trial;
  logic             qbit;

  // One restoring step
  always_comb begin
    trial    = {rem_r, work_r[NUM_W-1]};
    qbit     = (trial >= {1'b0, den_r});
    rem_nxt  = qbit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    work_nxt = {work_r[NUM_W-2:0], qbit};
    cnt_nxt  = cnt_r - CNT_W'(1);
  end

  // Iteration counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (cnt_r != '0) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign quot = work_r;

endmodule

@@ rtl/nnis_mem.sv @@
// ----------------------------------------------------------------------------
// nnis_mem: source frame store
// Single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module nnis_mem
  import nnis_pkg::*;
#(
  parameter int AW    = 20,
  parameter int DEPTH = 1048576
) (
  input  logic               clk,
  input  logic               we,
  input  logic               re,
  input  logic [AW-1:0]      addr,
  input  logic [PIXEL_W-1:0] wdata,
  output logic [PIXEL_W-1:0] rdata
);

  logic [PIXEL_W-1:0] mem [DEPTH];
  logic [PIXEL_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/nnis_checker.sv @@
// ----------------------------------------------------------------------------
// nnis_checker: port-level checks for the nearest neighbor scaler
// Watches the top level's ports only; attached by bind.
// ----------------------------------------------------------------------------
module nnis_checker
  import nnis_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input in_item_t             in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input out_item_t            out_data,
  input logic                 cfg_we
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed under stall");

  // Reset leaves no result and starts the step computation
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("bad state after reset");

  // Size write blocks input while steps are recomputed
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("input open during step recompute");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  // A write beat into an idle output produces no result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.req_type == REQ_WRITE) && !out_valid
      |=> ##1 !out_valid)
    else $error("result produced for a write beat");

endmodule

bind nearest_neighbour_image_scaler nnis_checker u_nnis_checker (.*);
